/* rtl/core/lzssd_pkg.sv */
// shared constants and types for the lzss stream decoder
package lzssd_pkg;

	localparam int RING_DEPTH_DEF  = 4096;
	localparam int PRESET_TAIL_DEF = 18;
	localparam int LEN_W           = 29;
	localparam int TOKENS_PER_FLAG = 8;
	localparam int MATCH_BIAS      = 3;

	localparam logic [LEN_W-1:0] MAX_OUTPUT = 29'h1000_0000;
	localparam logic [7:0]       SPACE_CHAR = 8'h20;

	typedef enum logic [1:0] {
		ST_BUSY = 2'd0,
		ST_DONE = 2'd1,
		ST_FAIL = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		status_t    status;
	} res_item_t;

endpackage

/* rtl/core/lzss_stream_decoder_top.sv */
// lzss stream decoder: byte sequencer over a 4096-byte history ring
// a literal goes from the decide state to the literal state, which loads the output register once it is ready
// items are taken one at a time: a new flag, literal or match byte is accepted only once the last is handled
// each copied byte takes a ring read state and an emit/write state on the one ring port pair
// reset: asynchronous, clears control state; the ring preset is served by a fill count,
// so no clearing pass is needed and items are taken right after reset
module lzss_stream_decoder_top #(
	parameter int RING_DEPTH  = lzssd_pkg::RING_DEPTH_DEF,
	parameter int PRESET_TAIL = lzssd_pkg::PRESET_TAIL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lzssd_pkg::LEN_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  in_byte,
	input  logic                        in_last,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [7:0]                  out_byte,
	output logic                        out_valid,
	output logic                        out_last,
	output logic [1:0]                  status
);
	import lzssd_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_LIT    = 6'b000100,
		S_RD     = 6'b001000,
		S_WR     = 6'b010000,
		S_STAT   = 6'b100000
	} state_t;

	state_t          state_q;
	logic [7:0]      byte_q;
	logic            last_q;
	logic [LEN_W-1:0] out_len_q;
	logic [LEN_W-1:0] produced_q;
	logic [7:0]      flags_q;
	logic [3:0]      flags_left_q;
	logic            phase_q;
	logic [7:0]      first_q;
	logic            finished_q;
	logic            failed_q;
	logic [AW-1:0]   src_q;
	logic [4:0]      rem_q;
	status_t         stat_q;

	logic            cmp_inc;
	logic [LEN_W:0]  cmp_sum;
	logic            cmp_ge;
	logic            too_big;
	logic            emit_last;
	status_t         emit_fin;
	logic            obuf_ready;
	logic            push;
	logic            emitting;
	res_item_t       item;
	res_item_t       item_q;
	logic            ring_rd_en;
	logic            ring_wr_en;
	logic [7:0]      ring_rd_data;

	assign in_stall = (state_q != S_IDLE);

	// shared add and compare: produced count, or count after this byte, against the length
	assign emitting = (state_q == S_LIT) || (state_q == S_WR);
	assign cmp_inc  = emitting;
	assign cmp_sum  = {1'b0, produced_q} + (LEN_W+1)'(cmp_inc);
	assign cmp_ge   = cmp_sum >= {1'b0, out_len_q};
	assign too_big  = out_len_q > MAX_OUTPUT;

	assign emit_last = (state_q == S_LIT) || cmp_ge || (rem_q == 5'd1);
	assign emit_fin  = cmp_ge ? ST_DONE : (last_q ? ST_FAIL : ST_BUSY);

	always_comb begin
		if (state_q == S_STAT) begin
			item.data   = 8'h00;
			item.valid  = 1'b0;
			item.last   = 1'b1;
			item.status = stat_q;
		end else begin
			item.data   = (state_q == S_LIT) ? byte_q : ring_rd_data;
			item.valid  = 1'b1;
			item.last   = emit_last;
			item.status = emit_last ? emit_fin : ST_BUSY;
		end
	end

	assign push       = (emitting || state_q == S_STAT) && obuf_ready;
	assign ring_wr_en = push && emitting;
	assign ring_rd_en = (state_q == S_RD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			byte_q       <= '0;
			last_q       <= 1'b0;
			out_len_q    <= '0;
			produced_q   <= '0;
			flags_q      <= '0;
			flags_left_q <= '0;
			phase_q      <= 1'b0;
			first_q      <= '0;
			finished_q   <= 1'b0;
			failed_q     <= 1'b0;
			src_q        <= '0;
			rem_q        <= '0;
			stat_q       <= ST_BUSY;
		end else begin
			if (cfg_we) begin
				out_len_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q  <= in_byte;
						last_q  <= in_last;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (finished_q) begin
						stat_q  <= failed_q ? ST_FAIL : ST_DONE;
						state_q <= S_STAT;
					end else if (too_big) begin
						stat_q     <= ST_FAIL;
						finished_q <= 1'b1;
						failed_q   <= 1'b1;
						state_q    <= S_STAT;
					end else if (cmp_ge) begin
						stat_q     <= ST_DONE;
						finished_q <= 1'b1;
						failed_q   <= 1'b0;
						state_q    <= S_STAT;
					end else if (phase_q) begin
						src_q   <= AW'({byte_q[7:4], first_q});
						rem_q   <= 5'(byte_q[3:0]) + 5'(MATCH_BIAS);
						state_q <= S_RD;
					end else if (flags_left_q != 4'd0 && flags_q[0]) begin
						state_q <= S_LIT;
					end else begin
						// flag byte or first match byte: no data, only a truncation report
						if (flags_left_q == 4'd0) begin
							flags_q      <= byte_q;
							flags_left_q <= 4'(TOKENS_PER_FLAG);
						end else begin
							first_q <= byte_q;
							phase_q <= 1'b1;
						end
						if (last_q) begin
							stat_q     <= ST_FAIL;
							finished_q <= 1'b1;
							failed_q   <= 1'b1;
							state_q    <= S_STAT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_LIT: begin
					if (obuf_ready) begin
						produced_q <= produced_q + LEN_W'(1);
						flags_q    <= flags_q >> 1;
						if (flags_left_q != 4'd0) begin
							flags_left_q <= flags_left_q - 4'd1;
						end
						if (emit_fin != ST_BUSY) begin
							finished_q <= 1'b1;
							failed_q   <= (emit_fin == ST_FAIL);
						end
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (obuf_ready) begin
						produced_q <= produced_q + LEN_W'(1);
						src_q      <= src_q + AW'(1);
						rem_q      <= rem_q - 5'd1;
						if (emit_last) begin
							// end of match, or length reached and the rest is dropped
							flags_q <= flags_q >> 1;
							if (flags_left_q != 4'd0) begin
								flags_left_q <= flags_left_q - 4'd1;
							end
							phase_q <= 1'b0;
							if (emit_fin != ST_BUSY) begin
								finished_q <= 1'b1;
								failed_q   <= (emit_fin == ST_FAIL);
							end
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_STAT: begin
					if (obuf_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	lzssd_ring #(
		.RING_DEPTH  (RING_DEPTH),
		.PRESET_TAIL (PRESET_TAIL)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ring_rd_en),
		.rd_addr (src_q),
		.rd_data (ring_rd_data),
		.wr_en   (ring_wr_en),
		.wr_data (item.data)
	);

	lzssd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.ready     (obuf_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.item_q    (item_q)
	);

	assign out_byte  = item_q.data;
	assign out_valid = item_q.valid;
	assign out_last  = item_q.last;
	assign status    = item_q.status;

	a_data_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		push && item.valid |-> state_q == S_LIT || state_q == S_WR)
		else $error("data item pushed outside an emit state");

	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_DECIDE)
		else $error("accepted item not decoded next cycle");

	a_final_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		push && item.last && item.status != ST_BUSY |=> finished_q)
		else $error("final status sent while stream still open");

	a_ring_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_rd_en && ring_wr_en))
		else $error("ring read and write in the same cycle");

endmodule

/* rtl/core/lzssd_ring.sv */
// history ring: one write port, one registered read port, preset tracked by fill count
module lzssd_ring #(
	parameter int RING_DEPTH  = 4096,
	parameter int PRESET_TAIL = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
	output logic [7:0]                    rd_data,
	input  logic                          wr_en,
	input  logic [7:0]                    wr_data
);
	import lzssd_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] START = AW'(RING_DEPTH - PRESET_TAIL);
	localparam logic [AW:0]   FULL  = (AW+1)'(RING_DEPTH);

	logic [7:0]    mem [RING_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW:0]   fill_q;
	logic [7:0]    mem_q;
	logic [7:0]    preset_q;
	logic          hit_q;
	logic [AW-1:0] rd_ofs;

	// entries written so far form one run that starts at the first write position
	assign rd_ofs = rd_addr - START;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
		if (rd_en) begin
			mem_q    <= mem[rd_addr];
			hit_q    <= {1'b0, rd_ofs} < fill_q;
			preset_q <= (rd_addr >= START) ? 8'h00 : SPACE_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= START;
			fill_q <= '0;
		end else if (wr_en) begin
			wp_q <= wp_q + AW'(1);
			if (fill_q != FULL) begin
				fill_q <= fill_q + (AW+1)'(1);
			end
		end
	end

	assign rd_data = hit_q ? mem_q : preset_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL) else $error("ring fill count past depth");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && fill_q != FULL |=> fill_q == $past(fill_q) + (AW+1)'(1))
		else $error("ring fill count missed a write");

endmodule

/* rtl/core/lzssd_obuf.sv */
// single-entry output register between the sequencer and the result channel
module lzssd_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lzssd_pkg::res_item_t item,
	output logic                 ready,
	output logic                 res_valid,
	input  logic                 res_stall,
	output lzssd_pkg::res_item_t item_q
);
	import lzssd_pkg::*;

	logic full_q;

	assign ready     = !full_q || !res_stall;
	assign res_valid = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push) begin
			full_q <= 1'b1;
		end else if (!res_stall) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q <= item;
		end
	end

endmodule
